FILE: rtl/core/sstf_pkg.sv
// Package with the types, codes and sizes shared by the scheduler modules.
`timescale 1ns / 1ps
`default_nettype none

package sstf_pkg;

    // Sizes of the request store and of the track numbers it holds.
    localparam int MAX_REQUESTS = 16;
    localparam int TRACK_BITS   = 16;
    localparam int IDX_BITS     = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_BITS     = $clog2(MAX_REQUESTS + 1);

    // Field widths of the transactions.
    localparam int POS_BITS    = 16;
    localparam int STATUS_BITS = 2;
    localparam int SUM_BITS    = 22;
    localparam int ADD_BITS    = ((SUM_BITS > TRACK_BITS) ? SUM_BITS : TRACK_BITS) + 1;
    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    // Operation codes of an input transaction.
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_RUN = 1'b1;

    // Status codes of a result transaction.
    localparam logic [STATUS_BITS-1:0] ST_SERVED = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY  = 2'd2;

    // Input transaction.
    typedef struct packed {
        logic                op;
        logic [POS_BITS-1:0] position;
    } item_t;

    // Result transaction.
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [POS_BITS-1:0]    served_position;
        logic [POS_BITS-1:0]    seek_distance;
        logic [SUM_BITS-1:0]    total_movement;
        logic                   last;
    } result_t;

    // Search token that walks down the cell chain, carrying the best candidate so far.
    typedef struct packed {
        logic                  valid;
        logic                  found;
        logic [TRACK_BITS-1:0] seek_dist;
        logic [IDX_BITS-1:0]   idx;
        logic [TRACK_BITS-1:0] track;
    } scan_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                  load_en;
        logic [IDX_BITS-1:0]   load_idx;
        logic [TRACK_BITS-1:0] load_track;
        logic                  serve_en;
        logic [IDX_BITS-1:0]   serve_idx;
        logic                  clear;
        logic [TRACK_BITS-1:0] head;
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/shortest_seek_first_scheduler.sv
// Shortest-seek-first scheduler: sequencer and the chain of request cells.
//
// Usage: an input transaction is taken at a rising edge with start high and busy low.
// An add transaction (op = 0) stores a request track and gives no result,
// unless the store is full, in which case one result with status 1 and last set follows
// in the next cycle. A run transaction (op = 1) loads the head track and serves every
// stored request, nearest first, ties to the earliest loaded one. Each service gives one
// result with the track, the seek distance and the saturating running total; the final
// one has last set. A run with no stored requests gives one result with status 2.
// A search token walks the chain of MAX_REQUESTS cells, one cell per cycle, and each
// served request takes one full sweep of the chain; while a run is busy no new
// transaction is taken. Results appear on result for exactly one cycle, marked by
// strobe; the receiver cannot stall them. After a run the store is empty. Reset
// empties the store, zeroes the head and the running total, and leaves the block idle.
`timescale 1ns / 1ps
`default_nettype none

module shortest_seek_first_scheduler (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire sstf_pkg::item_t item,
    output logic                 busy,
    output logic                 strobe,
    output sstf_pkg::result_t    result
);
    import sstf_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic [CNT_BITS-1:0]   done_reg;
    logic [CNT_BITS-1:0]   done_next;
    logic [TRACK_BITS-1:0] head_reg;
    logic [TRACK_BITS-1:0] head_next;
    logic [SUM_BITS-1:0]   sum_reg;
    logic [SUM_BITS-1:0]   sum_next;
    logic                  inject_reg;
    logic                  inject_next;
    logic                  strobe_reg;
    logic                  strobe_next;
    result_t               result_reg;
    result_t               result_next;

    logic                  accept;
    logic                  full;
    logic                  last_serve;
    logic [ADD_BITS-1:0]   sum_wide;
    logic [SUM_BITS-1:0]   sum_sat;
    logic [TRACK_BITS-1:0] pos_track;
    logic [MAX_REQUESTS-1:0] token_vec;
    cell_ctl_t             ctl;
    scan_t                 chain [0:MAX_REQUESTS];
    scan_t                 chain_out;

    assign accept    = start && !busy;
    assign full      = (count_reg == CNT_BITS'(MAX_REQUESTS));
    assign pos_track = TRACK_BITS'(item.position);
    assign chain_out = chain[MAX_REQUESTS];
    assign last_serve = (CNT_BITS'(done_reg + 1'b1) == count_reg);

    // Saturating running total of head movement.
    assign sum_wide = ADD_BITS'(sum_reg) + ADD_BITS'(chain_out.seek_dist);
    assign sum_sat  = (sum_wide > ADD_BITS'(SUM_MAX)) ? SUM_MAX : SUM_BITS'(sum_wide);

    // Broadcast to the cells: loads while idle, serve and clear at the end of a sweep.
    always_comb
    begin
        ctl.load_en    = accept && (item.op == OP_ADD) && !full;
        ctl.load_idx   = count_reg[IDX_BITS-1:0];
        ctl.load_track = pos_track;
        ctl.serve_en   = (state_reg == S_SCAN) && chain_out.valid;
        ctl.serve_idx  = chain_out.idx;
        ctl.clear      = (state_reg == S_SCAN) && chain_out.valid && last_serve;
        ctl.head       = head_reg;
    end

    // Token entering the first cell.
    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = inject_reg;
    end

    // The cell chain.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_REQUESTS; gi++)
        begin : g_cell
            sstf_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .idx      (IDX_BITS'(gi)),
                .ctl      (ctl),
                .scan_in  (chain[gi]),
                .scan_out (chain[gi + 1])
            );
            assign token_vec[gi] = chain[gi + 1].valid;
        end
    endgenerate

    // Sequencer: takes transactions while idle and runs one sweep per served request.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = done_reg;
        head_next   = head_reg;
        sum_next    = sum_reg;
        inject_next = 1'b0;
        strobe_next = 1'b0;
        result_next = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.op == OP_ADD)
                    begin
                        if (full)
                        begin
                            strobe_next        = 1'b1;
                            result_next.status = ST_FULL;
                            result_next.last   = 1'b1;
                        end
                        else
                        begin
                            count_next = CNT_BITS'(count_reg + 1'b1);
                        end
                    end
                    else
                    begin
                        head_next = pos_track;
                        sum_next  = '0;
                        done_next = '0;
                        if (count_reg == '0)
                        begin
                            strobe_next        = 1'b1;
                            result_next.status = ST_EMPTY;
                            result_next.last   = 1'b1;
                        end
                        else
                        begin
                            state_next  = S_SCAN;
                            inject_next = 1'b1;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (chain_out.valid)
                begin
                    head_next                   = chain_out.track;
                    sum_next                    = sum_sat;
                    done_next                   = CNT_BITS'(done_reg + 1'b1);
                    strobe_next                 = 1'b1;
                    result_next.status          = ST_SERVED;
                    result_next.served_position = POS_BITS'(chain_out.track);
                    result_next.seek_distance   = POS_BITS'(chain_out.seek_dist);
                    result_next.total_movement  = sum_sat;
                    result_next.last            = last_serve;
                    if (last_serve)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        inject_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            done_reg   <= '0;
            head_reg   <= '0;
            sum_reg    <= '0;
            inject_reg <= 1'b0;
            strobe_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            head_reg   <= head_next;
            sum_reg    <= sum_next;
            inject_reg <= inject_next;
            strobe_reg <= strobe_next;
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg == S_SCAN);
    assign strobe = strobe_reg;
    assign result = result_reg;

    // Only one search token is ever in the chain.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(token_vec))
        else $error("more than one search token in the cell chain");

    // A token reaching the end of the chain only happens during a run.
    a_token_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.valid |-> (state_reg == S_SCAN))
        else $error("search token finished outside a run");

    // Each sweep of a run finds an unserved request.
    a_sweep_found: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_out.valid && (state_reg == S_SCAN)) |-> chain_out.found)
        else $error("sweep ended without a candidate");

    // A run never proceeds with an empty store.
    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (count_reg != '0))
        else $error("run in progress with an empty store");

    // The final served result leaves the store empty.
    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && result_reg.last && (result_reg.status == ST_SERVED))
            |-> ((count_reg == '0) && (state_reg == S_IDLE)))
        else $error("store not emptied after the final result of a run");

endmodule

`default_nettype wire

FILE: rtl/core/sstf_cell.sv
// One cell of the request chain: holds one request and compares it against the passing token.
`timescale 1ns / 1ps
`default_nettype none

module sstf_cell (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [sstf_pkg::IDX_BITS-1:0]   idx,
    input  wire sstf_pkg::cell_ctl_t             ctl,
    input  wire sstf_pkg::scan_t                 scan_in,
    output sstf_pkg::scan_t                      scan_out
);
    import sstf_pkg::*;

    logic                  pending_reg;
    logic                  pending_next;
    logic [TRACK_BITS-1:0] track_reg;
    logic [TRACK_BITS-1:0] req_dist;
    logic                  take;
    scan_t                 scan_reg;
    scan_t                 scan_next;

    // The pending flag marks a loaded request that has not been served yet.
    always_comb
    begin
        pending_next = pending_reg;
        if (ctl.clear)
        begin
            pending_next = 1'b0;
        end
        else if (ctl.load_en && (ctl.load_idx == idx))
        begin
            pending_next = 1'b1;
        end
        else if (ctl.serve_en && (ctl.serve_idx == idx))
        begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // Request track storage, written only when this slot is loaded.
    always_ff @(posedge clk)
    begin
        if (ctl.load_en && (ctl.load_idx == idx))
        begin
            track_reg <= ctl.load_track;
        end
    end

    // Seek distance from the current head to this request.
    assign req_dist = (track_reg >= ctl.head) ? (track_reg - ctl.head)
                                              : (ctl.head - track_reg);

    // A strictly smaller distance wins, so ties stay with the earlier slot.
    assign take = scan_in.valid && pending_reg &&
                  (!scan_in.found || (req_dist < scan_in.seek_dist));

    always_comb
    begin
        scan_next = scan_in;
        if (take)
        begin
            scan_next.found     = 1'b1;
            scan_next.seek_dist = req_dist;
            scan_next.idx       = idx;
            scan_next.track     = track_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
        end
    end

    assign scan_out = scan_reg;

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench for the shortest-seek-first scheduler.
`timescale 1ns / 1ps

module tb_top;
    import sstf_pkg::*;

    // Settle time after the last result, in clock cycles.
    localparam int DRAIN_CYCLES = MAX_REQUESTS + 1;
    localparam int QUIET_LIMIT  = 20000;
    localparam int REPORT_LIMIT = 10;

    // One row of the directed stimulus; want is used only where typed is set.
    typedef struct {
        item_t   cmd;
        bit      typed;
        result_t want;
    } directed_row_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    item_t   item;
    logic    busy;
    logic    strobe;
    result_t result;

    // Private copy of the scheduler state, advanced on every accepted transaction.
    logic [TRACK_BITS-1:0] track_store [MAX_REQUESTS];
    bit                    served_mask [MAX_REQUESTS];
    int                    stored_count;
    logic [TRACK_BITS-1:0] head_pos;
    longint                movement_total;

    result_t       pending_results [$];
    result_t       step_results [$];
    directed_row_t directed_rows [$];
    result_t       no_result;
    int            fault_count = 0;

    shortest_seek_first_scheduler dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    // Free-running clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 0;
    end

    function automatic result_t make_result(logic [STATUS_BITS-1:0] status, longint pos,
                                            longint seek, longint total, bit last);
        result_t r;
        r.status          = status;
        r.served_position = pos[POS_BITS-1:0];
        r.seek_distance   = seek[POS_BITS-1:0];
        r.total_movement  = total[SUM_BITS-1:0];
        r.last            = last;
        return r;
    endfunction

    // Work out the results that one accepted transaction causes and update the state.
    task automatic predict_schedule(input item_t cmd);
        logic [TRACK_BITS-1:0] track;
        int                    best;
        longint                best_dist;
        longint                d;
        track = cmd.position;
        step_results.delete();
        if (cmd.op == OP_ADD)
        begin
            if (stored_count >= MAX_REQUESTS)
            begin
                step_results.push_back(make_result(ST_FULL, 0, 0, 0, 1'b1));
            end
            else
            begin
                track_store[stored_count] = track;
                served_mask[stored_count] = 1'b0;
                stored_count++;
            end
        end
        else
        begin
            head_pos       = track;
            movement_total = 0;
            if (stored_count == 0)
            begin
                step_results.push_back(make_result(ST_EMPTY, 0, 0, 0, 1'b1));
            end
            else
            begin
                // Serve the nearest unserved request each round; strict less-than
                // keeps the earliest loaded request on a tie.
                for (int n = 0; n < stored_count; n++)
                begin
                    best      = -1;
                    best_dist = 0;
                    for (int i = 0; i < stored_count; i++)
                    begin
                        if (!served_mask[i])
                        begin
                            d = (track_store[i] >= head_pos) ?
                                longint'(track_store[i]) - longint'(head_pos) :
                                longint'(head_pos) - longint'(track_store[i]);
                            if (best < 0 || d < best_dist)
                            begin
                                best      = i;
                                best_dist = d;
                            end
                        end
                    end
                    served_mask[best] = 1'b1;
                    head_pos          = track_store[best];
                    if (movement_total + best_dist > longint'(SUM_MAX))
                        movement_total = longint'(SUM_MAX);
                    else
                        movement_total = movement_total + best_dist;
                    step_results.push_back(make_result(ST_SERVED, head_pos, best_dist,
                                                       movement_total,
                                                       n == stored_count - 1));
                end
            end
            for (int i = 0; i < MAX_REQUESTS; i++)
                served_mask[i] = 1'b0;
            stored_count = 0;
        end
    endtask

    // Compare one result with its expectation, field by field.
    task automatic check_result(input result_t want, input result_t got);
        bit bad;
        bad = (got.status !== want.status) ||
              (got.served_position !== want.served_position) ||
              (got.seek_distance !== want.seek_distance) ||
              (got.total_movement !== want.total_movement) ||
              (got.last !== want.last);
        if (bad)
        begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
                $display("mismatch at %0t: expected st=%0d pos=%0d dist=%0d tot=%0d last=%0d, got st=%0d pos=%0d dist=%0d tot=%0d last=%0d",
                         $realtime, want.status, want.served_position, want.seek_distance,
                         want.total_movement, want.last, got.status, got.served_position,
                         got.seek_distance, got.total_movement, got.last);
        end
    endtask

    // Result monitor: every strobed result must match the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (strobe === 1'b1)
            begin
                if (pending_results.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("unexpected result at %0t: st=%0d pos=%0d", $realtime,
                                 result.status, result.served_position);
                end
                else
                begin
                    check_result(pending_results[0], result);
                    void'(pending_results.pop_front());
                end
            end
            else if (strobe !== 1'b0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("strobe unknown at %0t", $realtime);
            end
        end
    end

    // Offer one transaction after an optional random pause and wait until it is taken.
    task automatic send_item(input item_t cmd, input int idle_pct, input bit typed,
                             input result_t want);
        int gaps;
        gaps = 0;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct && gaps < 30)
        begin
            @(negedge clk);
            start <= 1'b0;
            gaps++;
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= cmd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_schedule(cmd);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (step_results[k])
                pending_results.push_back(step_results[k]);
    endtask

    // Hold off the sender until every expected result has arrived, then let the block settle.
    task automatic wait_quiet();
        int waited;
        waited = 0;
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0 && waited < QUIET_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            fault_count += pending_results.size();
            $display("%0d results never arrived", pending_results.size());
            pending_results.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic add_row(input logic op, input logic [POS_BITS-1:0] pos, input bit typed,
                           input result_t want);
        directed_row_t row;
        row.cmd.op       = op;
        row.cmd.position = pos;
        row.typed        = typed;
        row.want         = want;
        directed_rows.push_back(row);
    endtask

    // Track picker: spread over the disk, clustered near a base to force ties, or the extremes and the base.
    function automatic logic [POS_BITS-1:0] random_track(int mode, int base);
        int pick;
        case (mode)
            0: return POS_BITS'($urandom_range(65535));
            1: return POS_BITS'(base + $urandom_range(15));
            default:
            begin
                pick = $urandom_range(2);
                if (pick == 0)
                    return '0;
                else if (pick == 1)
                    return '1;
                else
                    return POS_BITS'(base);
            end
        endcase
    endfunction

    // Batches of adds closed by a run; a few batches are empty and a few fill or overfill the store.
    task automatic random_batches(input int idle_pct, input int quota);
        int    sent;
        int    n;
        int    mode;
        int    base;
        int    roll;
        item_t cmd;
        sent = 0;
        while (sent < quota)
        begin
            roll = $urandom_range(9);
            if (roll == 0)
                n = 0;
            else if (roll == 1)
                n = MAX_REQUESTS + $urandom_range(3);
            else
                n = $urandom_range(1, MAX_REQUESTS - 1);
            mode = $urandom_range(2);
            base = $urandom_range(65535);
            for (int j = 0; j < n; j++)
            begin
                cmd.op       = OP_ADD;
                cmd.position = random_track(mode, base);
                send_item(cmd, idle_pct, 1'b0, no_result);
                sent++;
            end
            cmd.op       = OP_RUN;
            cmd.position = random_track(mode, base);
            send_item(cmd, idle_pct, 1'b0, no_result);
            sent++;
        end
    endtask

    // Main stimulus: reset, directed table, then random phases with different idling.
    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        item           = '0;
        no_result      = '0;
        stored_count   = 0;
        head_pos       = '0;
        movement_total = 0;
        for (int i = 0; i < MAX_REQUESTS; i++)
        begin
            track_store[i] = '0;
            served_mask[i] = 1'b0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty run straight after reset, then single requests at the far ends of the disk.
        add_row(OP_RUN, 16'h0000, 1'b1, make_result(ST_EMPTY, 0, 0, 0, 1'b1));
        add_row(OP_ADD, 16'hFFFF, 1'b0, no_result);
        add_row(OP_RUN, 16'h0000, 1'b1, make_result(ST_SERVED, 65535, 65535, 65535, 1'b1));
        add_row(OP_ADD, 16'h0000, 1'b0, no_result);
        add_row(OP_RUN, 16'hFFFF, 1'b1, make_result(ST_SERVED, 0, 65535, 65535, 1'b1));
        // Equal distances on both sides of the head, loaded in both orders.
        add_row(OP_ADD, 16'd100, 1'b0, no_result);
        add_row(OP_ADD, 16'd300, 1'b0, no_result);
        add_row(OP_RUN, 16'd200, 1'b0, no_result);
        add_row(OP_ADD, 16'd300, 1'b0, no_result);
        add_row(OP_ADD, 16'd100, 1'b0, no_result);
        add_row(OP_RUN, 16'd200, 1'b0, no_result);
        // Full store, one rejected add, then a run from mid-disk.
        for (int k = 0; k < MAX_REQUESTS; k++)
            add_row(OP_ADD, (k % 3 == 0) ? 16'h0000 : (k % 3 == 1) ? 16'hFFFF : 16'(k * 1000),
                    1'b0, no_result);
        add_row(OP_ADD, 16'h1234, 1'b1, make_result(ST_FULL, 0, 0, 0, 1'b1));
        add_row(OP_RUN, 16'h8000, 1'b0, no_result);

        foreach (directed_rows[r])
            send_item(directed_rows[r].cmd, 0, directed_rows[r].typed, directed_rows[r].want);
        wait_quiet();

        random_batches(0, 70);
        wait_quiet();
        random_batches(71, 70);
        wait_quiet();
        random_batches(15, 70);
        wait_quiet();

        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
